[sv/dfh_pkg.sv]
// shared types, constants and helper functions for the digit fold hash insert unit
// no dependencies
package dfh_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int SIZE_W          = 9;
	localparam int SIZE_MAX        = (1 << SIZE_W) - 1;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(101);
	localparam int KEY_W           = 24;
	localparam int DIGIT_W         = 4;
	localparam int HASH_W          = 11;
	localparam int COLL_W          = 10;
	localparam logic [COLL_W-1:0] COLL_MAX = COLL_W'(1023);
	localparam int SLOT_OUT_W      = 8;
	localparam int QDEPTH          = 2;

	typedef struct packed {
		logic [SIZE_W-1:0]  home;
		logic [DIGIT_W-1:0] stride;
	} probe_req_t;

	typedef struct packed {
		logic              used;
		logic [COLL_W-1:0] coll;
	} slot_entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_HOME_RD,
		B_HOME_CHK,
		B_PROBE_RD,
		B_PROBE_CHK,
		B_OUT
	} back_state_t;

	// digit fold: 100*d5 + 10*d1 + d3
	function automatic logic [HASH_W-1:0] fold_hash(input logic [KEY_W-1:0] key);
		logic [HASH_W-1:0] d1;
		logic [HASH_W-1:0] d3;
		logic [HASH_W-1:0] d5;
		d1 = HASH_W'(key[19:16]);
		d3 = HASH_W'(key[11:8]);
		d5 = HASH_W'(key[3:0]);
		return HASH_W'(d5 * HASH_W'(100)) + HASH_W'(d1 * HASH_W'(10)) + d3;
	endfunction

	// single digit modulo the table size, four restoring steps
	function automatic logic [DIGIT_W-1:0] digit_mod(input logic [DIGIT_W-1:0] d,
		input logic [SIZE_W-1:0] size);
		logic [DIGIT_W:0] r;
		r = '0;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			r = {r[DIGIT_W-1:0], d[i]};
			if (SIZE_W'(r) >= size) begin
				r = r - (DIGIT_W + 1)'(size);
			end
		end
		return r[DIGIT_W-1:0];
	endfunction

endpackage

[sv/digit_fold_hash_probe_insert_unit.sv]
// channel     | dir | handshake                          | payload
// in          | in  | in_valid / in_stall                | key_digits
// out         | out | out_valid / out_stall              | placed_slot .. home_collisions
// table_size  | in  | table_size_valid / table_size_ready | table_size
//
// front: accepts a key, bit serial remainder (11 shifts and done), push once not full
// back: pops, reads and checks the home slot, then reads and checks each probe step; on a
// wrap to home it frees the first probed slot unless it is home, then hands over the result
// after reset the back clears all min(TABLE_DEPTH, 511) store slots, one slot a cycle;
// in_stall stays high meanwhile while table_size writes are taken as ever
// the result register lets the back start the next item while a result waits on out_stall
module digit_fold_hash_probe_insert_unit import dfh_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  table_size_valid,
	output logic                  table_size_ready,
	input  logic [SIZE_W-1:0]     table_size,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [KEY_W-1:0]      key_digits,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SLOT_OUT_W-1:0] placed_slot,
	output logic                  home_was_taken,
	output logic                  evicted,
	output logic [SLOT_OUT_W-1:0] freed_slot,
	output logic [COLL_W-1:0]     home_collisions
);

	// table_size never exceeds its 9 bits, so deeper stores are never reached
	localparam int STORE_DEPTH = (TABLE_DEPTH < SIZE_MAX) ? TABLE_DEPTH : SIZE_MAX;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] eff_size;
	logic              clearing;
	logic              push;
	probe_req_t        push_data;
	logic              full;
	logic              pop;
	probe_req_t        pop_data;
	logic              q_valid;

	assign table_size_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (table_size_valid && table_size_ready) begin
			size_q <= table_size;
		end
	end

	always_comb begin
		if (size_q == '0) begin
			eff_size = SIZE_W'(1);
		end else if (32'(size_q) > STORE_DEPTH) begin
			eff_size = SIZE_W'(STORE_DEPTH);
		end else begin
			eff_size = size_q;
		end
	end

	dfh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.eff_size   (eff_size),
		.hold       (clearing),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key_digits (key_digits),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	dfh_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_valid)
	);

	dfh_back #(.DEPTH(STORE_DEPTH)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.eff_size        (eff_size),
		.q_valid         (q_valid),
		.q_data          (pop_data),
		.q_pop           (pop),
		.clearing        (clearing),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.placed_slot     (placed_slot),
		.home_was_taken  (home_was_taken),
		.evicted         (evicted),
		.freed_slot      (freed_slot),
		.home_collisions (home_collisions)
	);

endmodule

[sv/dfh_mod.sv]
// bit serial restoring remainder of the folded hash by the table size
// depends on dfh_pkg
module dfh_mod import dfh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [SIZE_W-1:0] rem
);

	localparam int CNT_W = $clog2(HASH_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] dvd_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W:0]   trial;

	assign trial = {rem_q, dvd_q[HASH_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(HASH_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			if (trial >= (SIZE_W + 1)'(divisor)) begin
				rem_q <= SIZE_W'(trial - (SIZE_W + 1)'(divisor));
			end else begin
				rem_q <= trial[SIZE_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[sv/dfh_front.sv]
// front part: takes keys, folds the digits and reduces to home slot and stride
// depends on dfh_pkg and dfh_mod
module dfh_front import dfh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SIZE_W-1:0] eff_size,
	input  logic              hold,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KEY_W-1:0]  key_digits,
	output logic              push,
	output probe_req_t        push_data,
	input  logic              full
);

	front_state_t       state_q;
	front_state_t       state_nxt;
	logic               accept;
	logic               mod_done;
	logic [SIZE_W-1:0]  mod_rem;
	logic [SIZE_W-1:0]  home_q;
	logic [DIGIT_W-1:0] stride_q;

	dfh_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (fold_hash(key_digits)),
		.divisor  (eff_size),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			F_IDLE: if (in_valid && !hold) state_nxt = F_DIV;
			F_DIV:  if (mod_done) state_nxt = F_PUSH;
			F_PUSH: if (!full) state_nxt = F_IDLE;
			default: state_nxt = F_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		push     = 1'b0;
		unique case (state_q)
			F_IDLE:  in_stall = hold;
			F_DIV:   in_stall = 1'b1;
			F_PUSH:  push = !full;
			default: in_stall = 1'b1;
		endcase
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stride_q <= digit_mod(key_digits[23:20], eff_size);
		end
		if (mod_done) begin
			home_q <= mod_rem;
		end
	end

	assign push_data.home   = home_q;
	assign push_data.stride = stride_q;

endmodule

[sv/dfh_fifo.sv]
// short queue of probe requests between front and back
// depends on dfh_pkg
module dfh_fifo import dfh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  probe_req_t push_data,
	output logic       full,
	input  logic       pop,
	output probe_req_t pop_data,
	output logic       not_empty
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	probe_req_t       mem_q [QDEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule

[sv/dfh_table.sv]
// slot store: used flag and collision count per slot, one write and one read port
// depends on dfh_pkg
module dfh_table import dfh_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  slot_entry_t              wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output slot_entry_t              rdata
);

	slot_entry_t mem [DEPTH];
	slot_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/dfh_back.sv]
// back part: clearing pass, home check, stride probe, eviction and result register
// depends on dfh_pkg and dfh_table
module dfh_back import dfh_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [SIZE_W-1:0]     eff_size,
	input  logic                  q_valid,
	input  probe_req_t            q_data,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SLOT_OUT_W-1:0] placed_slot,
	output logic                  home_was_taken,
	output logic                  evicted,
	output logic [SLOT_OUT_W-1:0] freed_slot,
	output logic [COLL_W-1:0]     home_collisions
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int SUM_W = SIZE_W + 1;

	back_state_t        state_q;
	back_state_t        state_nxt;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [IDX_W-1:0]   home_q;
	logic [DIGIT_W-1:0] stride_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   first_q;
	logic [IDX_W-1:0]   place_q;
	logic               taken_q;
	logic               ev_q;
	logic [COLL_W-1:0]  coll_q;
	logic [COLL_W-1:0]  first_coll_q;

	logic                  out_valid_q;
	logic [SLOT_OUT_W-1:0] placed_slot_q;
	logic                  taken_out_q;
	logic                  evicted_q;
	logic [SLOT_OUT_W-1:0] freed_slot_q;
	logic [COLL_W-1:0]     coll_out_q;

	logic                    we;
	logic [IDX_W-1:0]        waddr;
	slot_entry_t             wdata;
	logic [IDX_W-1:0]        raddr;
	slot_entry_t             rdata;
	logic [COLL_W-1:0]       coll_inc;
	logic [IDX_W-1:0]        step_base;
	logic [SUM_W-1:0]        step_sum;
	logic [IDX_W-1:0]        step_pos;
	logic                    at_home;
	logic                    out_free;
	logic                    load_out;
	logic [IDX_W+SLOT_OUT_W-1:0] place_ext;
	logic [IDX_W+SLOT_OUT_W-1:0] first_ext;

	dfh_table #(.DEPTH(DEPTH)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign coll_inc = (rdata.coll == COLL_MAX) ? rdata.coll : rdata.coll + COLL_W'(1);

	// next probe position, sum stays below twice the size
	assign step_base = (state_q == B_HOME_CHK) ? home_q : pos_q;
	always_comb begin
		step_sum = SUM_W'(step_base) + SUM_W'(stride_q);
		if (step_sum >= SUM_W'(eff_size)) begin
			step_sum = step_sum - SUM_W'(eff_size);
		end
		step_pos = step_sum[IDX_W-1:0];
	end

	assign at_home  = (pos_q == home_q);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			B_CLEAR:     if (clr_idx_q == IDX_W'(DEPTH - 1)) state_nxt = B_IDLE;
			B_IDLE:      if (q_valid) state_nxt = B_HOME_RD;
			B_HOME_RD:   state_nxt = B_HOME_CHK;
			B_HOME_CHK:  state_nxt = rdata.used ? B_PROBE_RD : B_OUT;
			B_PROBE_RD:  state_nxt = at_home ? B_OUT : B_PROBE_CHK;
			B_PROBE_CHK: state_nxt = rdata.used ? B_PROBE_RD : B_OUT;
			B_OUT:       if (out_free) state_nxt = B_IDLE;
			default:     state_nxt = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		clearing = 1'b0;
		load_out = 1'b0;
		we       = 1'b0;
		waddr    = pos_q;
		wdata    = '0;
		raddr    = pos_q;
		unique case (state_q)
			B_CLEAR: begin
				clearing = 1'b1;
				we       = 1'b1;
				waddr    = clr_idx_q;
			end
			B_IDLE: begin
				q_pop = q_valid;
			end
			B_HOME_RD: begin
				raddr = home_q;
			end
			B_HOME_CHK: begin
				// home ends up used either way, count bumps only on a collision
				we         = 1'b1;
				waddr      = home_q;
				wdata.used = 1'b1;
				wdata.coll = rdata.used ? coll_inc : rdata.coll;
			end
			B_PROBE_RD: begin
				// wrapped to home: free the first probed slot unless it is home
				if (at_home && (first_q != home_q)) begin
					we         = 1'b1;
					waddr      = first_q;
					wdata.used = 1'b0;
					wdata.coll = first_coll_q;
				end
			end
			B_PROBE_CHK: begin
				if (!rdata.used) begin
					we         = 1'b1;
					waddr      = pos_q;
					wdata.used = 1'b1;
					wdata.coll = rdata.coll;
				end
			end
			B_OUT: begin
				load_out = out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == B_CLEAR) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			home_q   <= q_data.home[IDX_W-1:0];
			stride_q <= q_data.stride;
			ev_q     <= 1'b0;
		end
		if (state_q == B_HOME_CHK) begin
			taken_q <= rdata.used;
			coll_q  <= rdata.used ? coll_inc : rdata.coll;
			place_q <= home_q;
			pos_q   <= step_pos;
			first_q <= step_pos;
		end
		if ((state_q == B_PROBE_RD) && at_home) begin
			ev_q <= 1'b1;
		end
		if (state_q == B_PROBE_CHK) begin
			if (pos_q == first_q) begin
				first_coll_q <= rdata.coll;
			end
			if (rdata.used) begin
				pos_q <= step_pos;
			end else begin
				place_q <= pos_q;
			end
		end
	end

	assign place_ext = {{SLOT_OUT_W{1'b0}}, place_q};
	assign first_ext = {{SLOT_OUT_W{1'b0}}, first_q};

	always_ff @(posedge clk) begin
		if (load_out) begin
			placed_slot_q <= place_ext[SLOT_OUT_W-1:0];
			taken_out_q   <= taken_q;
			evicted_q     <= ev_q;
			freed_slot_q  <= ev_q ? first_ext[SLOT_OUT_W-1:0] : '0;
			coll_out_q    <= coll_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign placed_slot     = placed_slot_q;
	assign home_was_taken  = taken_out_q;
	assign evicted         = evicted_q;
	assign freed_slot      = freed_slot_q;
	assign home_collisions = coll_out_q;

endmodule

[sv/dfh_checker.sv]
// port level checks for the digit fold hash insert unit, bound to the top level
// depends on dfh_pkg
module dfh_checker import dfh_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [SLOT_OUT_W-1:0] placed_slot,
	input logic                  home_was_taken,
	input logic                  evicted,
	input logic [SLOT_OUT_W-1:0] freed_slot,
	input logic [COLL_W-1:0]     home_collisions
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(placed_slot)
			&& $stable(home_collisions) && $stable(evicted))
		else $error("result changed while stalled");

	a_freed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted |-> freed_slot == '0)
		else $error("freed slot set without eviction");

	a_evict_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> home_was_taken)
		else $error("eviction with a free home slot");

	a_coll_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && home_was_taken |-> home_collisions != '0)
		else $error("collision not counted");

	// the front works on one key at a time
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second key taken while the front is busy");

endmodule

bind digit_fold_hash_probe_insert_unit dfh_checker u_dfh_checker (.*);
